// ===== hdl/frpr_pkg.sv =====
// Package for the FIFO with prefix reversal: beat types, codes and defaults.
`default_nettype none
package frpr_pkg;

    localparam int DEPTH_DEF     = 128;
    localparam int WORD_BITS_DEF = 32;

    localparam int REQ_BITS   = 2;
    localparam int VALUE_BITS = 32;
    localparam int K_BITS     = 8;
    localparam int OCC_BITS   = 8;

    localparam logic [REQ_BITS-1:0] REQ_ENQ = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_DEQ = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REV = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_K     = 2'd3
    } status_t;

    typedef struct packed {
        logic [REQ_BITS-1:0]          req_type;
        logic signed [VALUE_BITS-1:0] value;
        logic [K_BITS-1:0]            prefix_count;
    } req_beat_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] data_out;
        status_t                      status;
        logic [OCC_BITS-1:0]          occupancy;
    } rsp_beat_t;

endpackage
`default_nettype wire

// ===== hdl/frpr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module frpr_ram
    import frpr_pkg::*;
#(
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/frpr_slot.sv =====
// Shared slot unit: base plus offset, wrapped round the circular buffer.
`default_nettype none
module frpr_slot
    import frpr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic [AW-1:0] base,
    input  wire logic [AW-1:0] offset,
    output logic      [AW-1:0] pos
);

    logic [AW:0] sum;

    always_comb begin
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (AW+1)'(DEPTH)) begin
            pos = AW'(sum - (AW+1)'(DEPTH));
        end else begin
            pos = sum[AW-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/frpr_seq.sv =====
// Sequencer: decodes a request, drives the RAM and slot unit, holds the result beat.
`default_nettype none
module frpr_seq
    import frpr_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire req_beat_t            s_req,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rsp_beat_t                 m_result,
    output logic                      mem_we,
    output logic      [AW-1:0]        mem_waddr,
    output logic      [WORD_BITS-1:0] mem_wdata,
    output logic      [AW-1:0]        mem_raddr,
    input  wire logic [WORD_BITS-1:0] mem_rdata,
    output logic      [AW-1:0]        slot_base,
    output logic      [AW-1:0]        slot_offset,
    input  wire logic [AW-1:0]        slot_pos
);

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CMPW = (CNTW > K_BITS) ? CNTW : K_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_DEQ    = 8'b0000_0100,
        S_RD_A   = 8'b0000_1000,
        S_RD_B   = 8'b0001_0000,
        S_WR_A   = 8'b0010_0000,
        S_WR_B   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    req_beat_t               req_reg, req_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CNTW-1:0]         count_reg, count_next;
    logic [AW-1:0]           lo_reg, lo_next;
    logic [AW-1:0]           hi_reg, hi_next;
    logic [AW-1:0]           addr_a_reg, addr_a_next;
    logic [AW-1:0]           addr_b_reg, addr_b_next;
    logic [WORD_BITS-1:0]    tmp_reg, tmp_next;
    logic signed [VALUE_BITS-1:0] data_reg, data_next;
    status_t                 status_reg, status_next;
    logic                    m_valid_reg, m_valid_next;
    rsp_beat_t               result_reg, result_next;

    logic [CMPW-1:0]      k_ext;
    logic [CMPW-1:0]      cnt_ext;
    logic [AW-1:0]        lo_inc;
    logic [AW-1:0]        hi_dec;
    logic [WORD_BITS-1:0] value_word;

    assign k_ext      = CMPW'(req_reg.prefix_count);
    assign cnt_ext    = CMPW'(count_reg);
    assign lo_inc     = lo_reg + AW'(1);
    assign hi_dec     = hi_reg - AW'(1);
    assign value_word = WORD_BITS'($unsigned(req_reg.value));
    assign slot_base  = head_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        addr_a_next  = addr_a_reg;
        addr_b_next  = addr_b_reg;
        tmp_next     = tmp_reg;
        data_next    = data_reg;
        status_next  = status_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot_pos;
        mem_wdata    = value_word;
        mem_raddr    = slot_pos;
        slot_offset  = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                data_next   = '0;
                status_next = ST_OK;
                state_next  = S_RESP;
                case (req_reg.req_type)
                    REQ_ENQ: begin
                        slot_offset = count_reg[AW-1:0];
                        if (count_reg == CNTW'(DEPTH)) begin
                            status_next = ST_OVERFLOW;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNTW'(1);
                        end
                    end
                    REQ_DEQ: begin
                        if (count_reg == '0) begin
                            status_next = ST_UNDERFLOW;
                        end else begin
                            mem_raddr  = head_reg;
                            state_next = S_DEQ;
                        end
                    end
                    REQ_REV: begin
                        if (k_ext > cnt_ext) begin
                            status_next = ST_BAD_K;
                        end else if (req_reg.prefix_count >= K_BITS'(2)) begin
                            lo_next    = '0;
                            hi_next    = AW'(req_reg.prefix_count - K_BITS'(1));
                            state_next = S_RD_A;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DEQ: begin
                // The read of the head slot was issued in the decode cycle.
                slot_offset = AW'(1);
                head_next   = slot_pos;
                count_next  = count_reg - CNTW'(1);
                data_next   = $signed(VALUE_BITS'(mem_rdata));
                state_next  = S_RESP;
            end
            S_RD_A: begin
                slot_offset = lo_reg;
                addr_a_next = slot_pos;
                state_next  = S_RD_B;
            end
            S_RD_B: begin
                slot_offset = hi_reg;
                addr_b_next = slot_pos;
                tmp_next    = mem_rdata;
                state_next  = S_WR_A;
            end
            S_WR_A: begin
                // Read data now holds the younger entry of the pair.
                mem_we     = 1'b1;
                mem_waddr  = addr_a_reg;
                mem_wdata  = mem_rdata;
                state_next = S_WR_B;
            end
            S_WR_B: begin
                mem_we    = 1'b1;
                mem_waddr = addr_b_reg;
                mem_wdata = tmp_reg;
                lo_next   = lo_inc;
                hi_next   = hi_dec;
                if (lo_inc < hi_dec) begin
                    state_next = S_RD_A;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    result_next.data_out  = data_reg;
                    result_next.status    = status_reg;
                    result_next.occupancy = OCC_BITS'(count_reg);
                    m_valid_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        addr_a_reg <= addr_a_next;
        addr_b_reg <= addr_b_next;
        tmp_reg    <= tmp_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

endmodule
`default_nettype wire

// ===== hdl/fifo_with_prefix_reverse.sv =====
// Top level of the FIFO with in-place reversal of its oldest entries.
// A request beat is taken only while the block is idle. An enqueue, an
// underflowing dequeue, an invalid or trivial reverse and the unused request
// code go from decode straight to the response step; a dequeue passes through
// a read step first; a reverse of k entries performs floor(k/2) swaps, and each
// swap needs two reads and two writes through the single read port and single
// write port of the entry RAM, addressed by one shared wrap-round slot adder.
// The result beat sits in an output register, so the next request is taken
// while it waits; the block only stalls at its response step when the
// previous result has still not been taken.
`default_nettype none
module fifo_with_prefix_reverse
    import frpr_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire req_beat_t s_req,
    output logic           m_valid,
    input  wire logic      m_ready,
    output rsp_beat_t      m_result
);

    localparam int AW = $clog2(DEPTH);

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [AW-1:0]        slot_base;
    logic [AW-1:0]        slot_offset;
    logic [AW-1:0]        slot_pos;

    frpr_seq #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .slot_base   (slot_base),
        .slot_offset (slot_offset),
        .slot_pos    (slot_pos)
    );

    frpr_slot #(
        .DEPTH (DEPTH)
    ) u_slot (
        .base   (slot_base),
        .offset (slot_offset),
        .pos    (slot_pos)
    );

    frpr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ===== hdl/frpr_chk.sv =====
// Port-level checker for the FIFO with prefix reversal, bound to the top level.
`default_nettype none
module frpr_chk
    import frpr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire rsp_beat_t m_result
);

    // A stalled result beat must hold.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result beat changed while stalled");

    // One request at a time: ready drops straight after a beat is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    // An overflow is only reported when the queue is full.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.status == ST_OVERFLOW |->
            (DEPTH > 255) || m_result.occupancy == OCC_BITS'(DEPTH))
        else $error("overflow reported with room left");

    // An underflow leaves the queue empty and returns zero.
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.status == ST_UNDERFLOW |->
            m_result.occupancy == '0 && m_result.data_out == '0)
        else $error("underflow reported on a non-empty queue");

    // Occupancy never exceeds the depth.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (DEPTH > 255) || m_result.occupancy <= OCC_BITS'(DEPTH))
        else $error("occupancy beyond depth");

endmodule

bind fifo_with_prefix_reverse frpr_chk #(.DEPTH(DEPTH)) u_frpr_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);
`default_nettype wire
